>>> sv/swfq_pkg.sv
// ----------------------------------------------------------------------------
// Sensor window feature quantizer package
// Shared types, feature codes and fixed-point quantizer constants.
// ----------------------------------------------------------------------------
`default_nettype none

package swfq_pkg;

	// Field widths of one sample and one quantized feature.
	localparam int TEMP_W  = 15;
	localparam int HUMI_W  = 14;
	localparam int LIGHT_W = 16;
	localparam int Q_W     = 8;

	// Multiplier width of the quantizer reciprocal (32 fraction bits).
	localparam int K_W = 32;

	// Offsets that move each raw feature onto its 0..scale range.
	localparam int T_OFS       = 4000;
	localparam int DELTA_OFS   = 1000;
	localparam int L_DELTA_OFS = 500;

	// Quantizer step in units of 1e-9, and 2^32 * 1e9.
	localparam logic [63:0] Q_STEP  = 64'd2502752;
	localparam logic [63:0] Q_NUMER = 64'd4294967296 * 64'd1000000000;

	// Denominators of the features whose scale does not depend on the window.
	localparam logic [63:0] DEN_T_NOW   = 64'd16500;
	localparam logic [63:0] DEN_H_NOW   = 64'd10000;
	localparam logic [63:0] DEN_L_NOW   = 64'd2000;
	localparam logic [63:0] DEN_DELTA   = 64'd2000;
	localparam logic [63:0] DEN_L_DELTA = 64'd1000;

	// Rounded reciprocals K = round(2^32 * 1e9 / (den * step)).
	localparam logic [K_W-1:0] K_T_NOW =
		K_W'((Q_NUMER + (DEN_T_NOW * Q_STEP) / 64'd2) / (DEN_T_NOW * Q_STEP));
	localparam logic [K_W-1:0] K_H_NOW =
		K_W'((Q_NUMER + (DEN_H_NOW * Q_STEP) / 64'd2) / (DEN_H_NOW * Q_STEP));
	localparam logic [K_W-1:0] K_L_NOW =
		K_W'((Q_NUMER + (DEN_L_NOW * Q_STEP) / 64'd2) / (DEN_L_NOW * Q_STEP));
	localparam logic [K_W-1:0] K_DELTA =
		K_W'((Q_NUMER + (DEN_DELTA * Q_STEP) / 64'd2) / (DEN_DELTA * Q_STEP));
	localparam logic [K_W-1:0] K_L_DELTA =
		K_W'((Q_NUMER + (DEN_L_DELTA * Q_STEP) / 64'd2) / (DEN_L_DELTA * Q_STEP));

	// Feature codes, in the order the sequencer issues them.
	typedef enum logic [2:0] {
		FEAT_T_NOW   = 3'd0,
		FEAT_H_NOW   = 3'd1,
		FEAT_L_NOW   = 3'd2,
		FEAT_T_DELTA = 3'd3,
		FEAT_H_DELTA = 3'd4,
		FEAT_L_DELTA = 3'd5,
		FEAT_T_MEAN  = 3'd6,
		FEAT_H_MEAN  = 3'd7
	} feat_t;

	// One sensor sample.
	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centi;
		logic        [HUMI_W-1:0] humidity_centi;
		logic        [LIGHT_W-1:0] light_lux;
	} sample_t;

	// One result: ready flag and eight quantized features.
	typedef struct packed {
		logic                  features_ready;
		logic signed [Q_W-1:0] q_temp_now;
		logic signed [Q_W-1:0] q_humi_now;
		logic signed [Q_W-1:0] q_light_now;
		logic signed [Q_W-1:0] q_temp_delta;
		logic signed [Q_W-1:0] q_humi_delta;
		logic signed [Q_W-1:0] q_light_delta;
		logic signed [Q_W-1:0] q_temp_mean;
		logic signed [Q_W-1:0] q_humi_mean;
	} result_t;

	// Tag that travels with one operand set through the quantizer.
	typedef struct packed {
		logic  vld;
		feat_t idx;
	} quant_tag_t;

	// Quantized feature leaving the quantizer.
	typedef struct packed {
		logic                  vld;
		feat_t                 idx;
		logic signed [Q_W-1:0] q;
	} quant_res_t;

endpackage

`default_nettype wire

>>> sv/swfq_window_mem.sv
// ----------------------------------------------------------------------------
// Sample window memory
// Single-port circular window store with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swfq_window_mem #(
	parameter int DEPTH  = 8,
	parameter int WIDTH  = 29,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write the newest sample; the read returns the old contents of the slot.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/swfq_quant_unit.sv
// ----------------------------------------------------------------------------
// Shared feature quantizer
// Clamps a numerator to 0..den, multiplies by the rounded reciprocal and
// rounds half up to a saturated int8 code; two register stages, one feature
// a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swfq_quant_unit #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 18
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire swfq_pkg::quant_tag_t     tag,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]         den,
	input  wire logic [swfq_pkg::K_W-1:0] k,
	output swfq_pkg::quant_res_t          res
);

	import swfq_pkg::*;

	localparam int P_W = DEN_W + K_W;
	localparam int R_W = P_W - 31;

	quant_tag_t              tag_s1;
	quant_tag_t              tag_s2;
	logic [DEN_W-1:0]        n_s1;
	logic [K_W-1:0]          k_s1;
	logic [P_W-1:0]          prod_s2;
	logic signed [NUM_W-1:0] den_ext;
	logic [DEN_W-1:0]        n_clamp;
	logic [P_W:0]            rnd;
	logic [R_W-1:0]          r;

	// Clip the numerator to the range 0..den.
	always_comb begin
		den_ext = $signed({{(NUM_W - DEN_W){1'b0}}, den});
		if (num < 0) begin
			n_clamp = '0;
		end else if (num > den_ext) begin
			n_clamp = den;
		end else begin
			n_clamp = num[DEN_W-1:0];
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	// Operand and product registers.
	always_ff @(posedge clk) begin
		n_s1    <= n_clamp;
		k_s1    <= k;
		prod_s2 <= P_W'(n_s1) * P_W'(k_s1);
	end

	// Round half up, drop the fraction, shift by -128 and saturate at 127.
	always_comb begin
		rnd     = {1'b0, prod_s2} + {{(P_W - 31){1'b0}}, 1'b1, 31'd0};
		r       = rnd[P_W:32];
		res.vld = tag_s2.vld;
		res.idx = tag_s2.idx;
		if (r > R_W'(255)) begin
			res.q = 8'sd127;
		end else begin
			res.q = $signed({~r[7], r[6:0]});
		end
	end

endmodule

`default_nettype wire

>>> sv/sensor_window_feature_quantizer_top.sv
// Flow: a sample that fills or finds a full window goes through the window
// update, the eight issues to the shared quantizer, one feature at a time, and
// the finish state; one before the window is full goes from the update to the
// finish state with a zero result. A new sample is taken only back in idle.
// Reset: arst_n clears the fill count, window sums, sequencer and result
// valid at once; window memory contents are not cleared.
// ----------------------------------------------------------------------------
// Sensor window feature quantizer
// Keeps a sliding window of temperature and humidity samples with running
// sums, and turns each sample into eight int8 features once the window fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_window_feature_quantizer_top #(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire swfq_pkg::sample_t sample,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output swfq_pkg::result_t      result
);

	import swfq_pkg::*;

	localparam int LOG_D    = $clog2(WINDOW_DEPTH);
	localparam int PTR_W    = LOG_D;
	localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_T_W  = TEMP_W + LOG_D;
	localparam int SUM_H_W  = HUMI_W + LOG_D;
	localparam int NUM_W    = 18 + LOG_D;
	localparam int DEN_W    = 15 + LOG_D;
	localparam int MEM_W    = TEMP_W + HUMI_W;

	// Window-mean denominators and reciprocals.
	localparam logic [63:0] DEN_T_MEAN = 64'(WINDOW_DEPTH) * DEN_T_NOW;
	localparam logic [63:0] DEN_H_MEAN = 64'(WINDOW_DEPTH) * DEN_H_NOW;
	localparam logic [K_W-1:0] K_T_MEAN =
		K_W'((Q_NUMER + (DEN_T_MEAN * Q_STEP) / 64'd2) / (DEN_T_MEAN * Q_STEP));
	localparam logic [K_W-1:0] K_H_MEAN =
		K_W'((Q_NUMER + (DEN_H_MEAN * Q_STEP) / 64'd2) / (DEN_H_MEAN * Q_STEP));

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                    state_q;
	sample_t                   in_q;
	logic [CNT_W-1:0]          fill_q;
	logic [PTR_W-1:0]          wp_q;
	logic signed [SUM_T_W-1:0] sum_t_q;
	logic [SUM_H_W-1:0]        sum_h_q;
	logic signed [TEMP_W-1:0]  t_prev_q;
	logic [HUMI_W-1:0]         h_prev_q;
	logic [LIGHT_W-1:0]        l_prev_q;
	logic                      rdy_q;
	feat_t                     issue_idx_q;
	logic                      issue_done_q;
	logic signed [Q_W-1:0]     feat_q [8];
	result_t                   result_q;
	logic                      result_valid_q;

	logic                      mem_we;
	logic [MEM_W-1:0]          mem_wdata;
	logic [MEM_W-1:0]          mem_rdata;
	logic signed [TEMP_W-1:0]  old_t;
	logic [HUMI_W-1:0]         old_h;
	logic                      full_now;
	logic                      rdy_now;
	logic                      out_free;

	quant_tag_t                q_tag;
	quant_res_t                q_res;
	logic signed [NUM_W-1:0]   q_num;
	logic [DEN_W-1:0]          q_den;
	logic [K_W-1:0]            q_k;
	logic signed [NUM_W-1:0]   t_ext;
	logic signed [NUM_W-1:0]   tp_ext;
	logic signed [NUM_W-1:0]   h_ext;
	logic signed [NUM_W-1:0]   hp_ext;
	logic signed [NUM_W-1:0]   l_ext;
	logic signed [NUM_W-1:0]   lp_ext;
	result_t                   result_nxt;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	// Window store: the slot at the write pointer holds the oldest sample.
	assign mem_we    = (state_q == ST_UPD);
	assign mem_wdata = {in_q.temperature_centi, in_q.humidity_centi};
	assign old_t     = $signed(mem_rdata[MEM_W-1:HUMI_W]);
	assign old_h     = mem_rdata[HUMI_W-1:0];
	assign full_now  = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign rdy_now   = (fill_q >= CNT_W'(WINDOW_DEPTH - 1));

	swfq_window_mem #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (MEM_W),
		.ADDR_W(PTR_W)
	) u_window_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (wp_q),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Operand select for the feature being issued.
	always_comb begin
		t_ext  = NUM_W'(in_q.temperature_centi);
		tp_ext = NUM_W'(t_prev_q);
		h_ext  = $signed(NUM_W'(in_q.humidity_centi));
		hp_ext = $signed(NUM_W'(h_prev_q));
		l_ext  = $signed(NUM_W'(in_q.light_lux));
		lp_ext = $signed(NUM_W'(l_prev_q));
		unique case (issue_idx_q)
			FEAT_T_NOW: begin
				q_num = t_ext + NUM_W'(T_OFS);
				q_den = DEN_W'(DEN_T_NOW);
				q_k   = K_T_NOW;
			end
			FEAT_H_NOW: begin
				q_num = h_ext;
				q_den = DEN_W'(DEN_H_NOW);
				q_k   = K_H_NOW;
			end
			FEAT_L_NOW: begin
				q_num = l_ext;
				q_den = DEN_W'(DEN_L_NOW);
				q_k   = K_L_NOW;
			end
			FEAT_T_DELTA: begin
				q_num = t_ext - tp_ext + NUM_W'(DELTA_OFS);
				q_den = DEN_W'(DEN_DELTA);
				q_k   = K_DELTA;
			end
			FEAT_H_DELTA: begin
				q_num = h_ext - hp_ext + NUM_W'(DELTA_OFS);
				q_den = DEN_W'(DEN_DELTA);
				q_k   = K_DELTA;
			end
			FEAT_L_DELTA: begin
				q_num = l_ext - lp_ext + NUM_W'(L_DELTA_OFS);
				q_den = DEN_W'(DEN_L_DELTA);
				q_k   = K_L_DELTA;
			end
			FEAT_T_MEAN: begin
				q_num = NUM_W'(sum_t_q) + NUM_W'(WINDOW_DEPTH * T_OFS);
				q_den = DEN_W'(DEN_T_MEAN);
				q_k   = K_T_MEAN;
			end
			FEAT_H_MEAN: begin
				q_num = $signed(NUM_W'(sum_h_q));
				q_den = DEN_W'(DEN_H_MEAN);
				q_k   = K_H_MEAN;
			end
		endcase
		q_tag.vld = (state_q == ST_RUN) && !issue_done_q;
		q_tag.idx = issue_idx_q;
	end

	swfq_quant_unit #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_quant_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.tag   (q_tag),
		.num   (q_num),
		.den   (q_den),
		.k     (q_k),
		.res   (q_res)
	);

	// Result assembly: all zero until the window is full.
	always_comb begin
		result_nxt = '0;
		if (rdy_q) begin
			result_nxt.features_ready = 1'b1;
			result_nxt.q_temp_now     = feat_q[FEAT_T_NOW];
			result_nxt.q_humi_now     = feat_q[FEAT_H_NOW];
			result_nxt.q_light_now    = feat_q[FEAT_L_NOW];
			result_nxt.q_temp_delta   = feat_q[FEAT_T_DELTA];
			result_nxt.q_humi_delta   = feat_q[FEAT_H_DELTA];
			result_nxt.q_light_delta  = feat_q[FEAT_L_DELTA];
			result_nxt.q_temp_mean    = feat_q[FEAT_T_MEAN];
			result_nxt.q_humi_mean    = feat_q[FEAT_H_MEAN];
		end
	end

	// Sequencer, window bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			wp_q           <= '0;
			sum_t_q        <= '0;
			sum_h_q        <= '0;
			rdy_q          <= 1'b0;
			issue_idx_q    <= FEAT_T_NOW;
			issue_done_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// A new result takes the output register as the old one leaves it.
			if (state_q == ST_FIN && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// Running sums drop the evicted sample once the window is full.
					sum_t_q <= sum_t_q + SUM_T_W'(in_q.temperature_centi)
						- (full_now ? SUM_T_W'(old_t) : SUM_T_W'(0));
					sum_h_q <= sum_h_q + SUM_H_W'(in_q.humidity_centi)
						- (full_now ? SUM_H_W'(old_h) : SUM_H_W'(0));
					if (!full_now) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					if (wp_q == PTR_W'(WINDOW_DEPTH - 1)) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + PTR_W'(1);
					end
					rdy_q        <= rdy_now;
					issue_idx_q  <= FEAT_T_NOW;
					issue_done_q <= 1'b0;
					state_q      <= rdy_now ? ST_RUN : ST_FIN;
				end
				ST_RUN: begin
					if (!issue_done_q) begin
						if (issue_idx_q == FEAT_H_MEAN) begin
							issue_done_q <= 1'b1;
						end else begin
							issue_idx_q <= feat_t'(issue_idx_q + 3'd1);
						end
					end
					if (q_res.vld && q_res.idx == FEAT_H_MEAN) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request capture, previous sample, features, result.
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			in_q <= sample;
		end
		if (q_res.vld) begin
			feat_q[q_res.idx] <= q_res.q;
		end
		if (state_q == ST_FIN && out_free) begin
			result_q <= result_nxt;
			t_prev_q <= in_q.temperature_centi;
			h_prev_q <= in_q.humidity_centi;
			l_prev_q <= in_q.light_lux;
		end
	end

	// A request always moves the sequencer into the window update.
	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> (state_q == ST_UPD))
		else $error("accepted request did not start the window update");

	// Quantized features only come back while the sequencer is running.
	a_res_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_res.vld |-> (state_q == ST_RUN))
		else $error("quantizer result outside the run phase");

	// Fill count and write pointer stay inside the window.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= CNT_W'(WINDOW_DEPTH)) && (wp_q <= PTR_W'(WINDOW_DEPTH - 1)))
		else $error("fill count or write pointer out of range");

	// A result from a partly filled window carries all-zero features.
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.features_ready) |->
		(result.q_temp_now == '0) && (result.q_humi_now == '0) &&
		(result.q_light_now == '0) && (result.q_temp_delta == '0) &&
		(result.q_humi_delta == '0) && (result.q_light_delta == '0) &&
		(result.q_temp_mean == '0) && (result.q_humi_mean == '0))
		else $error("non-zero feature in a not-ready result");

endmodule

`default_nettype wire

>>> sim/swfq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor window feature quantizer result checker
// Watches both handshakes of the block. Every accepted sample request
// updates a private copy of the window and predicts the result it causes.
// Every accepted result is compared field by field with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------

module swfq_result_checker #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_ready,
	input  swfq_pkg::sample_t sample,
	input  logic              result_valid,
	input  logic              result_ready,
	input  swfq_pkg::result_t result,
	output int                failures,
	output int                outstanding
);
	import swfq_pkg::*;

	// Quantizer step in units of 1e-9, the scale 2^32 * 1e9 and the rounding bias.
	localparam longint unsigned QUANT_STEP  = 64'd2502752;
	localparam longint unsigned QUANT_SCALE = 64'd4294967296 * 64'd1000000000;
	localparam longint unsigned ROUND_HALF  = 64'h0000_0000_8000_0000;

	// Offsets and full-scale spans of the features, in input units.
	localparam longint TEMP_SHIFT        = 4000;
	localparam longint DELTA_SHIFT       = 1000;
	localparam longint LIGHT_DELTA_SHIFT = 500;
	localparam longint SPAN_TEMP         = 16500;
	localparam longint SPAN_HUMI         = 10000;
	localparam longint SPAN_LIGHT        = 2000;
	localparam longint SPAN_DELTA        = 2000;
	localparam longint SPAN_LIGHT_DELTA  = 1000;

	// Private copy of the sample history.
	longint temp_hist [WINDOW_DEPTH];
	longint humi_hist [WINDOW_DEPTH];
	longint light_last;
	int     fill;

	// Results predicted for accepted requests, oldest first.
	result_t expected_results [$];
	int      mismatch_count;

	// Clip num to 0..span, scale by the rounded reciprocal and saturate.
	function automatic logic signed [Q_W-1:0] quantize(input longint num, input longint span);
		longint unsigned recip;
		longint unsigned clipped;
		longint unsigned scaled;
		longint          q;
		recip = (QUANT_SCALE + (span * QUANT_STEP) / 2) / (span * QUANT_STEP);
		if (num < 0) begin
			clipped = 0;
		end else if (num > span) begin
			clipped = span;
		end else begin
			clipped = num;
		end
		scaled = (clipped * recip + ROUND_HALF) >> 32;
		q = longint'(scaled) - 128;
		if (q > 127) begin
			q = 127;
		end
		return q[Q_W-1:0];
	endfunction

	// Shift one sample into the history and queue the result it causes.
	task automatic absorb_sample(input sample_t s);
		result_t want;
		longint  t;
		longint  h;
		longint  l;
		longint  l_prev;
		longint  sum_t;
		longint  sum_h;
		int      i;
		t = longint'($signed(s.temperature_centi));
		h = longint'(s.humidity_centi);
		l = longint'(s.light_lux);
		l_prev = light_last;
		light_last = l;
		if (fill < WINDOW_DEPTH) begin
			temp_hist[fill] = t;
			humi_hist[fill] = h;
			fill++;
		end else begin
			for (i = 0; i < WINDOW_DEPTH - 1; i++) begin
				temp_hist[i] = temp_hist[i + 1];
				humi_hist[i] = humi_hist[i + 1];
			end
			temp_hist[WINDOW_DEPTH - 1] = t;
			humi_hist[WINDOW_DEPTH - 1] = h;
		end

		// A window that is not yet full gives an all-zero result.
		want = '0;
		if (fill == WINDOW_DEPTH) begin
			sum_t = 0;
			sum_h = 0;
			for (i = 0; i < WINDOW_DEPTH; i++) begin
				sum_t += temp_hist[i];
				sum_h += humi_hist[i];
			end
			want.features_ready = 1'b1;
			want.q_temp_now    = quantize(t + TEMP_SHIFT, SPAN_TEMP);
			want.q_humi_now    = quantize(h, SPAN_HUMI);
			want.q_light_now   = quantize(l, SPAN_LIGHT);
			want.q_temp_delta  = quantize(t - temp_hist[WINDOW_DEPTH - 2] + DELTA_SHIFT,
				SPAN_DELTA);
			want.q_humi_delta  = quantize(h - humi_hist[WINDOW_DEPTH - 2] + DELTA_SHIFT,
				SPAN_DELTA);
			want.q_light_delta = quantize(l - l_prev + LIGHT_DELTA_SHIFT, SPAN_LIGHT_DELTA);
			want.q_temp_mean   = quantize(sum_t + WINDOW_DEPTH * TEMP_SHIFT,
				WINDOW_DEPTH * SPAN_TEMP);
			want.q_humi_mean   = quantize(sum_h, WINDOW_DEPTH * SPAN_HUMI);
		end
		expected_results.push_back(want);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic compare_result(input result_t want, input result_t got);
		check_field("features_ready", int'(want.features_ready), int'(got.features_ready));
		check_field("q_temp_now",     int'(want.q_temp_now),     int'(got.q_temp_now));
		check_field("q_humi_now",     int'(want.q_humi_now),     int'(got.q_humi_now));
		check_field("q_light_now",    int'(want.q_light_now),    int'(got.q_light_now));
		check_field("q_temp_delta",   int'(want.q_temp_delta),   int'(got.q_temp_delta));
		check_field("q_humi_delta",   int'(want.q_humi_delta),   int'(got.q_humi_delta));
		check_field("q_light_delta",  int'(want.q_light_delta),  int'(got.q_light_delta));
		check_field("q_temp_mean",    int'(want.q_temp_mean),    int'(got.q_temp_mean));
		check_field("q_humi_mean",    int'(want.q_humi_mean),    int'(got.q_humi_mean));
	endtask

	// Sample both channels at the clock edge where a handshake completes.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				absorb_sample(sample);
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result accepted with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					compare_result(want, result);
				end
			end
		end
		failures    <= mismatch_count;
		outstanding <= expected_results.size();
	end

endmodule

>>> sim/tb_sensor_window_feature_quantizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor window feature quantizer testbench
// Drives directed samples at the field extremes and clip edges, then random
// sensor walks mixed with full-range noise, in bursts with random gaps.
// The result side stalls on changing patterns, including one long hold-off.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_sensor_window_feature_quantizer_top;
	import swfq_pkg::*;

	localparam int RANDOM_SAMPLES = 1930;
	localparam int DRAIN_PAUSE_AT = 1200;
	localparam int HOLD_START     = 6000;
	localparam int HOLD_CYCLES    = 400;
	localparam int MODE_SPAN      = 200;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 20;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_RARELY,
		RX_PERIODIC
	} rx_mode_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	int      failures;
	int      outstanding;

	// Last values handed out, so random walks continue from them.
	int last_temp  = 0;
	int last_humi  = 5000;
	int last_light = 1000;

	sensor_window_feature_quantizer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	swfq_result_checker result_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic sample_t pack_sample(input int t, input int h, input int l);
		sample_t s;
		s.temperature_centi = t[TEMP_W-1:0];
		s.humidity_centi    = h[HUMI_W-1:0];
		s.light_lux         = l[LIGHT_W-1:0];
		last_temp  = t;
		last_humi  = h;
		last_light = l;
		return s;
	endfunction

	// Mostly plausible sensor walks, some independent in-range samples, some noise.
	function automatic sample_t next_sample();
		int kind;
		int t;
		int h;
		int l;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			t = clamp(last_temp + int'($urandom_range(0, 2200)) - 1100, -4500, 13000);
			h = clamp(last_humi + int'($urandom_range(0, 2200)) - 1100, 0, 10500);
			l = clamp(last_light + int'($urandom_range(0, 1200)) - 600, 0, 2200);
		end else if (kind < 8) begin
			t = int'($urandom_range(0, 16500)) - 4000;
			h = $urandom_range(0, 10000);
			l = $urandom_range(0, 2000);
		end else begin
			t = int'($urandom_range(0, 32767)) - 16384;
			h = $urandom_range(0, 16383);
			l = $urandom_range(0, 65535);
		end
		return pack_sample(t, h, l);
	endfunction

	// Present one request and hold it until the block accepts it.
	task automatic offer(input sample_t s);
		sample       <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Stimulus and verdict.
	initial begin
		int issued;
		int burst;
		int drain_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window filling, with the field extremes while no features come out.
		offer(pack_sample(-16384, 0, 0));
		offer(pack_sample(16383, 16383, 65535));
		offer(pack_sample(0, 0, 0));
		offer(pack_sample(-4000, 0, 0));
		offer(pack_sample(12500, 10000, 2000));
		offer(pack_sample(1234, 5000, 1000));
		offer(pack_sample(-4000, 0, 0));

		// Full window: zero-scale and full-scale points, clipping both ways.
		offer(pack_sample(-4000, 0, 0));
		offer(pack_sample(12500, 10000, 2000));
		offer(pack_sample(2500, 0, 0));
		offer(pack_sample(16383, 16383, 65535));
		offer(pack_sample(-16384, 0, 0));
		offer(pack_sample(-16384, 0, 0));

		// Deltas landing exactly on the ends of their range.
		offer(pack_sample(-15384, 1000, 500));
		offer(pack_sample(-16384, 0, 0));
		offer(pack_sample(4250, 5000, 1000));
		offer(pack_sample(4251, 5001, 1001));
		offer(pack_sample(0, 16383, 0));
		offer(pack_sample(16383, 0, 65535));
		offer(pack_sample(-1, 1, 1));

		// Random requests in bursts, with one pause until the block drains.
		issued = 0;
		while (issued < RANDOM_SAMPLES) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && issued < RANDOM_SAMPLES) begin
				offer(next_sample());
				issued++;
				burst--;
				if (issued == DRAIN_PAUSE_AT) begin
					sample_valid <= 1'b0;
					do @(posedge clk); while (outstanding != 0);
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				sample_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		sample_valid <= 1'b0;

		// Let the last results come out, then let the clock run on quietly before the verdict.
		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (outstanding != 0 && drain_cycles < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
		end
		if (failures == 0 && outstanding == 0) begin
			$display("tb_sensor_window_feature_quantizer_top passed");
		end else begin
			$display("tb_sensor_window_feature_quantizer_top failed");
		end
		$finish;
	end

	// Result side: stall patterns that change periodically, picked at random,
	// plus one long hold-off so the block backs up into its input.
	initial begin
		int       cycle;
		rx_mode_t mode;
		cycle = 0;
		mode  = RX_ALWAYS;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % MODE_SPAN == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
			end
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
				result_ready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS: begin
						result_ready <= 1'b1;
					end
					RX_MOSTLY: begin
						result_ready <= ($urandom_range(0, 3) != 0);
					end
					RX_RARELY: begin
						result_ready <= ($urandom_range(0, 4) == 0);
					end
					default: begin
						result_ready <= ((cycle % 7) < 3);
					end
				endcase
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("tb_sensor_window_feature_quantizer_top failed");
		$finish;
	end

endmodule
